>>> src/wma_pkg.sv
// Shared constants for the warm-up moving-average filter.
package wma_pkg;

  // Default ring depth and sample width.
  localparam int DEF_DEPTH        = 8;
  localparam int DEF_SAMPLE_WIDTH = 24;

  // Width of the samples_held result field.
  localparam int HELD_WIDTH = 4;

endpackage

>>> src/warmup_moving_average_core.sv
// Top level of the warm-up moving-average filter.
// Boxcar moving average over the last DEPTH samples, with a warm-up phase:
// until DEPTH samples have arrived after reset, the mean is taken over the
// samples received so far, and samples_held reports that count. Each result
// is the sum of held samples divided by the count, truncated toward zero.
// Every accepted item yields exactly one result item. The engine divides
// a SUM_W-bit sum, where SUM_W = SAMPLE_WIDTH + clog2(DEPTH), with a serial
// divider that produces one quotient bit per cycle. A two-entry input queue
// and a result register let both sides stall independently. No clearing
// pass is needed after reset.
module warmup_moving_average_core #(
  parameter int DEPTH        = wma_pkg::DEF_DEPTH,
  parameter int SAMPLE_WIDTH = wma_pkg::DEF_SAMPLE_WIDTH,
  localparam int IN_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_WIDTH + wma_pkg::HELD_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // sample
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // average, samples_held
);

  logic                    q_valid;
  logic                    q_ready;
  logic [SAMPLE_WIDTH-1:0] q_sample;

  // Input queue.
  wma_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_sample  (q_sample)
  );

  // Filter engine.
  wma_back #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_sample   (q_sample),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> src/wma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module wma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/wma_front.sv
// Input side: accepts sample items and queues them for the filter engine.
module wma_front #(
  parameter int SAMPLE_WIDTH = wma_pkg::DEF_SAMPLE_WIDTH,
  localparam int IN_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_W-1:0]         in_tdata,
  output logic                    q_valid,
  input  logic                    q_ready,
  output logic [SAMPLE_WIDTH-1:0] q_sample
);

  logic [SAMPLE_WIDTH-1:0] slot_r [2];
  logic                    wr_ptr_r;
  logic                    rd_ptr_r;
  logic [1:0]              count_r;
  logic                    push;
  logic                    pop;

  // Bits above the sample width are dropped when a sample is written to the queue.
  assign in_tready = (count_r != 2'd2);
  assign q_valid   = (count_r != 2'd0);
  assign q_sample  = slot_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  // Two-entry queue storage, no reset needed on payload.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_tdata[SAMPLE_WIDTH-1:0];
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

>>> src/wma_back.sv
// Filter engine: ring update, running sum, serial divide and result register.
module wma_back #(
  parameter int DEPTH        = wma_pkg::DEF_DEPTH,
  parameter int SAMPLE_WIDTH = wma_pkg::DEF_SAMPLE_WIDTH,
  localparam int OUT_W = ((SAMPLE_WIDTH + wma_pkg::HELD_WIDTH + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  logic [SAMPLE_WIDTH-1:0] q_sample,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_W-1:0]        out_tdata
);

  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int BITS_W = $clog2(SUM_W + 1);
  localparam int HELD_W = wma_pkg::HELD_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t                     state_r;
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic [AW-1:0]              wp_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic                       neg_r;
  logic [SUM_W-1:0]           quo_r;
  logic [CNT_W-1:0]           rem_r;
  logic [BITS_W-1:0]          bits_r;
  logic                       out_valid_r;
  logic [SAMPLE_WIDTH-1:0]    out_avg_r;
  logic [HELD_W-1:0]          out_held_r;

  logic [SAMPLE_WIDTH-1:0]    ram_rdata;
  logic                       ram_we;
  logic                       full;
  logic signed [SAMPLE_WIDTH-1:0] old_s;
  logic signed [SUM_W:0]      acc;
  logic [CNT_W:0]             rem_sh;
  logic [CNT_W:0]             diff;
  logic [SUM_W-1:0]           quo_neg;
  logic [HELD_W+CNT_W-1:0]    held_ext;
  logic                       out_free;

  // Sample ring; reads are issued on the cycle an item is popped.
  wma_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (sample_r),
    .raddr (wp_r),
    .rdata (ram_rdata)
  );

  // Slots not yet written since reset hold undefined data; they are exactly those
  // at or above the fill count, so ring data is used only once the ring is full.
  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign old_s   = full ? $signed(ram_rdata) : '0;
  assign acc     = (SUM_W+1)'(sum_r) - (SUM_W+1)'(old_s) + (SUM_W+1)'(sample_r);
  assign ram_we  = (state_r == ST_READ);
  assign q_ready = (state_r == ST_IDLE);

  // One restoring step of the unsigned divide of |sum| by the fill count.
  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign diff    = rem_sh - {1'b0, cnt_r};
  assign quo_neg = SUM_W'(0) - quo_r;

  // Fill count masked to the result field.
  assign held_ext = {{HELD_W{1'b0}}, cnt_r};
  assign out_free = !out_valid_r || out_tready;

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A taken result clears the register unless the next one loads it.
      if (out_valid_r && out_tready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            sample_r <= q_sample;
            state_r  <= ST_READ;
          end
        end
        ST_READ: begin
          sum_r <= acc[SUM_W-1:0];
          if (wp_r == AW'(DEPTH - 1)) begin
            wp_r <= '0;
          end else begin
            wp_r <= wp_r + AW'(1);
          end
          if (!full) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
          state_r <= ST_PREP;
        end
        ST_PREP: begin
          neg_r   <= sum_r[SUM_W-1];
          quo_r   <= sum_r[SUM_W-1] ? (SUM_W'(0) - sum_r) : sum_r;
          rem_r   <= '0;
          bits_r  <= BITS_W'(SUM_W);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (!diff[CNT_W]) begin
            rem_r <= diff[CNT_W-1:0];
          end else begin
            rem_r <= rem_sh[CNT_W-1:0];
          end
          quo_r  <= {quo_r[SUM_W-2:0], ~diff[CNT_W]};
          bits_r <= bits_r - BITS_W'(1);
          if (bits_r == BITS_W'(1)) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_avg_r   <= neg_r ? quo_neg[SAMPLE_WIDTH-1:0] : quo_r[SAMPLE_WIDTH-1:0];
            out_held_r  <= held_ext[HELD_W-1:0];
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_held_r, out_avg_r});

endmodule
